[sv/pilr_pkg.sv]
// Shared constants, types and helpers for the positional insert/remove list.
package pilr_pkg;

  // List geometry
  localparam int DEPTH       = 512;
  localparam int ENTRY_WIDTH = 32;

  // Fixed field widths of the stream items
  localparam int ACT_W   = 1;
  localparam int POS_W   = 10;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 10;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 48;
  localparam int S_PAD_W  = S_DATA_W - ACT_W - POS_W - VAL_W;
  localparam int M_PAD_W  = M_DATA_W - VAL_W - STAT_W - OCNT_W;

  // Internal widths
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  // Fan-in of one node of the read-out tree
  localparam int FAN = 8;

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic                   ins;
    logic                   rem;
    logic [CMP_W-1:0]       pos;
    logic [ENTRY_WIDTH-1:0] value;
  } cmd_t;

  // Number of nodes at a given tree level (level 0 holds the cell taps)
  function automatic int level_nodes(input int lvl);
    int n;
    n = DEPTH;
    for (int i = 0; i < lvl; i++) begin
      n = (n + FAN - 1) / FAN;
    end
    return n;
  endfunction

  // Number of registered tree levels down to a single node
  function automatic int tree_levels();
    int n;
    int l;
    n = DEPTH;
    l = 0;
    while (n > 1 || l == 0) begin
      n = (n + FAN - 1) / FAN;
      l++;
    end
    return l;
  endfunction

  // Offset of a level's nodes in the flat node store (levels from 1)
  function automatic int level_offset(input int lvl);
    int off;
    off = 0;
    for (int i = 1; i < lvl; i++) begin
      off += level_nodes(i);
    end
    return off;
  endfunction

  localparam int LEVELS      = tree_levels();
  localparam int TREE_NODES  = level_offset(LEVELS + 1);

endpackage

[sv/pilr_cell.sv]
// One list slot: holds an entry and shifts with its neighbors on insert or remove.
module pilr_cell
  import pilr_pkg::*;
(
  input  logic                   clk,
  input  logic [CMP_W-1:0]       idx,        // fixed slot number
  input  cmd_t                   cmd,
  input  logic [ENTRY_WIDTH-1:0] left_data,  // slot idx-1
  input  logic [ENTRY_WIDTH-1:0] right_data, // slot idx+1
  output logic [ENTRY_WIDTH-1:0] data,
  output logic [ENTRY_WIDTH-1:0] tap         // entry when this slot is removed, else zero
);

  // Slot update: load the value at an insert position, shift up above it, shift down from a remove
  always_ff @(posedge clk) begin
    if (cmd.ins && idx > cmd.pos) begin
      data <= left_data;
    end else if (cmd.ins && idx == cmd.pos) begin
      data <= cmd.value;
    end else if (cmd.rem && idx >= cmd.pos) begin
      data <= right_data;
    end
  end

  // Read-out tap for the removed entry
  assign tap = (cmd.rem && idx == cmd.pos) ? data : '0;

endmodule

[sv/pilr_or_tree.sv]
// Registered OR-reduction tree that gathers the removed entry from the cell taps.
module pilr_or_tree
  import pilr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [ENTRY_WIDTH-1:0] taps [DEPTH],
  output logic                   done,
  output logic [ENTRY_WIDTH-1:0] value
);

  logic [ENTRY_WIDTH-1:0] node [TREE_NODES];
  logic [LEVELS-1:0]      vld;

  // One registered level per pass, FAN inputs per node
  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int NIN  = level_nodes(l - 1);
    localparam int NOUT = level_nodes(l);
    localparam int OFF  = level_offset(l);
    localparam int POFF = level_offset(l - 1);
    for (genvar k = 0; k < NOUT; k++) begin : g_node
      localparam int NJ = ((NIN - k * FAN) < FAN) ? (NIN - k * FAN) : FAN;
      logic [ENTRY_WIDTH-1:0] acc;
      if (l == 1) begin : g_leaf
        always_comb begin
          acc = '0;
          for (int j = 0; j < NJ; j++) begin
            acc = acc | taps[k * FAN + j];
          end
        end
      end else begin : g_inner
        always_comb begin
          acc = '0;
          for (int j = 0; j < NJ; j++) begin
            acc = acc | node[POFF + k * FAN + j];
          end
        end
      end
      always_ff @(posedge clk) begin
        node[OFF + k] <= acc;
      end
    end
  end

  // Valid bits travel with the levels
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[0] <= start;
      for (int i = 1; i < LEVELS; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  assign done  = vld[LEVELS-1];
  assign value = node[TREE_NODES-1];

endmodule

[sv/positional_insert_remove_list.sv]
// Positional insert/remove list: a row of DEPTH shifting cells with a registered read-out tree.
// The removed entry passes through LEVELS registered OR-tree levels of fan-in 8 and then the
// result register. A new request is taken only the cycle after the previous result is taken,
// so one request is in flight at a time. All cells shift in the accept cycle.
// Reset (rst, synchronous): count cleared to zero, control idle; slot data is not cleared.
module positional_insert_remove_list
  import pilr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // action[0], position[10:1], entry_value[42:11]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // removed_value[31:0], status[33:32], count[43:34]
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WAIT = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cnt_next;
  logic [VAL_W-1:0]       out_removed;
  status_t                out_status;
  logic [OCNT_W-1:0]      out_count;

  logic                   action;
  logic [POS_W-1:0]       position;
  logic [VAL_W-1:0]       entry_value;
  logic [CMP_W-1:0]       pos_x;
  logic [CMP_W-1:0]       cnt_x;
  logic                   acc;
  logic                   ins_ok;
  logic                   rem_ok;
  status_t                dec_status;
  cmd_t                   cmd;

  logic [ENTRY_WIDTH-1:0] cell_data [DEPTH];
  logic [ENTRY_WIDTH-1:0] cell_tap  [DEPTH];
  logic                   tree_done;
  logic [ENTRY_WIDTH-1:0] tree_value;

  // Request fields
  assign action      = s_tdata[0];
  assign position    = s_tdata[POS_W:1];
  assign entry_value = s_tdata[POS_W+VAL_W:POS_W+1];
  assign pos_x       = CMP_W'(position);
  assign cnt_x       = CMP_W'(cnt);

  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid && s_tready;

  // Request check: full/empty before the position check
  always_comb begin
    ins_ok     = 1'b0;
    rem_ok     = 1'b0;
    dec_status = STAT_OK;
    cnt_next   = cnt;
    if (action == ACT_INSERT) begin
      if (cnt == CNT_W'(DEPTH)) begin
        dec_status = STAT_FULL;
      end else if (pos_x > cnt_x) begin
        dec_status = STAT_RANGE;
      end else begin
        ins_ok   = 1'b1;
        cnt_next = cnt + 1'b1;
      end
    end else begin
      if (cnt == '0) begin
        dec_status = STAT_EMPTY;
      end else if (pos_x >= cnt_x) begin
        dec_status = STAT_RANGE;
      end else begin
        rem_ok   = 1'b1;
        cnt_next = cnt - 1'b1;
      end
    end
  end

  // Command broadcast to the cells
  assign cmd.ins   = acc && ins_ok;
  assign cmd.rem   = acc && rem_ok;
  assign cmd.pos   = pos_x;
  assign cmd.value = ENTRY_WIDTH'(entry_value);

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left_in;
    logic [ENTRY_WIDTH-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    pilr_cell u_cell (
      .clk        (clk),
      .idx        (CMP_W'(i)),
      .cmd        (cmd),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // Removed-entry read-out
  pilr_or_tree u_tree (
    .clk   (clk),
    .rst   (rst),
    .start (acc),
    .taps  (cell_tap),
    .done  (tree_done),
    .value (tree_value)
  );

  // Control and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            cnt   <= cnt_next;
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (tree_done) begin
            state <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (acc) begin
      out_status <= dec_status;
      out_count  <= OCNT_W'(cnt_next);
    end
    if (state == ST_WAIT && tree_done) begin
      out_removed <= VAL_W'(tree_value);
    end
  end

  assign m_tvalid = (state == ST_SEND);
  assign m_tdata  = {{M_PAD_W{1'b0}}, out_count, out_status, out_removed};

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    tree_done |-> state == ST_WAIT)
    else $error("tree result outside wait state");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> cnt == CNT_W'($past(cnt) + 1'b1))
    else $error("count not raised by insert");

  a_fail_hold: assert property (@(posedge clk) disable iff (rst)
    acc && !ins_ok && !rem_ok |=> cnt == $past(cnt))
    else $error("failed request changed count");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status != STAT_OK |-> out_removed == '0)
    else $error("nonzero removed value on failed request");
`endif

endmodule

[test/testbench.sv]
// Testbench for the positional insert/remove list: directed and random requests against a predictor.
`timescale 1ns / 1ps

module testbench;
  import pilr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 16;
  localparam int MAX_PRINTS  = 40;

  // Expected result of one request
  typedef struct {
    logic [VAL_W-1:0]  removed;
    status_t           status;
    logic [OCNT_W-1:0] count;
  } list_result_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // action[0], position[10:1], entry_value[42:11]
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // removed_value[31:0], status[33:32], count[43:34]

  // Predictor state: shadow copy of the list
  logic [ENTRY_WIDTH-1:0] shadow_list [DEPTH];
  int                     shadow_len;
  list_result_t           pending_results [$];
  list_result_t           oldest_result;

  int  error_count;
  int  stall_cycles;
  logic steady;

  positional_insert_remove_list DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Print a mismatch (up to MAX_PRINTS of them) and count it
  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    if (error_count < MAX_PRINTS) begin
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    error_count++;
  endtask

  // Apply one accepted request to the shadow list and queue its result
  function automatic void predict_list_op(input logic act, input logic [POS_W-1:0] pos,
                                          input logic [VAL_W-1:0] val);
    list_result_t r;
    r.removed = '0;
    if (act == ACT_INSERT) begin
      if (shadow_len >= DEPTH) begin
        r.status = STAT_FULL;
      end else if (pos > shadow_len) begin
        r.status = STAT_RANGE;
      end else begin
        for (int i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[pos] = val[ENTRY_WIDTH-1:0];
        shadow_len++;
        r.status = STAT_OK;
      end
    end else begin
      if (shadow_len == 0) begin
        r.status = STAT_EMPTY;
      end else if (pos >= shadow_len) begin
        r.status = STAT_RANGE;
      end else begin
        r.removed = shadow_list[pos];
        shadow_len--;
        for (int i = pos; i < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
        r.status = STAT_OK;
      end
    end
    r.count = shadow_len[OCNT_W-1:0];
    pending_results.push_back(r);
  endfunction

  // Send one request; valid stays high afterwards unless a gap is taken next time
  task automatic send_request(input logic act, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    if (!steady && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{S_PAD_W{1'b0}}, val, pos, act};
    do @(posedge clk); while (!s_tready);
    predict_list_op(act, pos, val);
  endtask

  // Random request: mostly valid positions, some anywhere in the field's range
  task automatic send_random(input int insert_pct, input int noise_pct);
    logic             act;
    logic [POS_W-1:0] pos;
    act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
    if ($urandom_range(0, 99) < noise_pct) begin
      pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    end else if (act == ACT_INSERT) begin
      pos = POS_W'($urandom_range(0, shadow_len));
    end else begin
      pos = (shadow_len == 0) ? '0 : POS_W'($urandom_range(0, shadow_len - 1));
    end
    send_request(act, pos, $urandom);
  endtask

  // Empty list, out-of-range positions, front/middle/end inserts and front/end removes
  task automatic test_edge_cases();
    send_request(ACT_REMOVE, 10'd0, 32'h0000_0000);
    send_request(ACT_REMOVE, 10'd1023, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 10'd1, 32'h1234_5678);
    send_request(ACT_INSERT, 10'd1023, 32'h8765_4321);
    send_request(ACT_INSERT, 10'd0, 32'h0000_0000);
    send_request(ACT_INSERT, 10'd1, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 10'd0, 32'hA5A5_A5A5);
    send_request(ACT_INSERT, 10'd1, 32'h5A5A_5A5A);
    send_request(ACT_INSERT, 10'd5, 32'hDEAD_BEEF);
    send_request(ACT_REMOVE, 10'd4, 32'h0000_0000);
    send_request(ACT_REMOVE, 10'd512, 32'h0000_0000);
    send_request(ACT_REMOVE, 10'd3, 32'hFFFF_FFFF);
    send_request(ACT_REMOVE, 10'd0, 32'h0000_0000);
    send_request(ACT_REMOVE, 10'd1, 32'h0000_0000);
    send_request(ACT_REMOVE, 10'd0, 32'h0000_0000);
    send_request(ACT_REMOVE, 10'd0, 32'h0000_0000);
  endtask

  // Grow to full, push against the full list, then drain part way
  task automatic test_fill_and_drain();
    steady = 1'b1;
    while (shadow_len < DEPTH) begin
      if (shadow_len > DEPTH / 3) steady = 1'b0;
      send_random(97, 2);
    end
    send_request(ACT_INSERT, 10'd0, $urandom);
    send_request(ACT_INSERT, 10'd512, $urandom);
    send_request(ACT_INSERT, 10'd1023, $urandom);
    send_request(ACT_REMOVE, 10'd512, $urandom);
    send_request(ACT_REMOVE, 10'd511, $urandom);
    send_request(ACT_INSERT, 10'd511, $urandom);
    send_request(ACT_REMOVE, 10'd0, $urandom);
    send_request(ACT_INSERT, 10'd0, $urandom);
    repeat (6) send_random(50, 50);
    repeat (20) send_random(15, 5);
    send_request(ACT_REMOVE, POS_W'($urandom_range(0, (1 << POS_W) - 1)), $urandom);
  endtask

  // Mixed traffic with the insert share chosen anew for every block
  task automatic test_random_churn();
    int insert_pct;
    for (int blk = 0; blk < 6; blk++) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 25;
        1: insert_pct = 50;
        default: insert_pct = 75;
      endcase
      repeat (5) send_random(insert_pct, 10);
    end
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 15);
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", m_tdata[VAL_W-1:0], '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_tdata[VAL_W-1:0] !== oldest_result.removed)
          report_mismatch("removed_value", m_tdata[VAL_W-1:0], oldest_result.removed);
        if (m_tdata[VAL_W+STAT_W-1:VAL_W] !== oldest_result.status)
          report_mismatch("status", m_tdata[VAL_W+STAT_W-1:VAL_W], oldest_result.status);
        if (m_tdata[VAL_W+STAT_W+OCNT_W-1:VAL_W+STAT_W] !== oldest_result.count)
          report_mismatch("count", m_tdata[VAL_W+STAT_W+OCNT_W-1:VAL_W+STAT_W],
                          oldest_result.count);
      end
    end
  end

  // Watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Test sequence
  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    steady       = 1'b0;
    shadow_len   = 0;
    error_count  = 0;
    stall_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_cases();
    test_fill_and_drain();
    test_random_churn();

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/pilr_pkg.sv
sv/pilr_cell.sv
sv/pilr_or_tree.sv
sv/positional_insert_remove_list.sv
test/testbench.sv
